// ===== sv/mp2d_pkg.sv =====
// Shared constants, register codes and controller/datapath handshake types
// for the 2D max pooling block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mp2d_pkg;

  // Sizing of the frame, the window and the samples
  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4096;
  localparam int MAX_KERNEL = 8;
  localparam int DATA_WIDTH = 16;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int BANK_W = $clog2(MAX_KERNEL);

  // Configuration register widths
  localparam int FW_W       = 12;
  localparam int FH_W       = 13;
  localparam int KS_W       = 4;
  localparam int WS_W       = 4;
  localparam int CFG_DATA_W = 13;

  // Reset values of the configuration registers
  localparam logic [FW_W-1:0] FW_RESET = FW_W'(1200);
  localparam logic [FH_W-1:0] FH_RESET = FH_W'(1200);
  localparam logic [KS_W-1:0] KS_RESET = KS_W'(5);
  localparam logic [WS_W-1:0] WS_RESET = WS_W'(5);

  // Pooled index divider: dividend width and step counter width
  localparam int DIV_W     = ROW_W;
  localparam int DIV_CNT_W = $clog2(DIV_W + 1);

  // Configuration register index codes
  typedef enum logic [1:0] {
    CFG_FRAME_WIDTH   = 2'd0,
    CFG_FRAME_HEIGHT  = 2'd1,
    CFG_POOL_SIDE     = 2'd2,
    CFG_WINDOW_STRIDE = 2'd3
  } cfg_reg_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic take;       // pixel channel ready
    logic shift;      // push the column max into the shift line
    logic div_start;  // start the pooled row/column dividers
    logic emit;       // load the result register
  } dp_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic in_valid;   // a pixel word is offered
    logic row_ok;     // enough rows for a full window column
    logic col_ok;     // enough columns for a full window
    logic div_done;   // dividers finished
    logic rem_zero;   // window origin on the stride grid
    logic out_free;   // result register can take a word
  } dp_sts_t;

endpackage

`default_nettype wire

// ===== sv/mp2d_channels.sv =====
// Valid/ready channel interfaces: pixel words in, pooled result words out.
// Depends on mp2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface mp2d_pixel_if;
  import mp2d_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pixel;
  logic                         frame_start;

  modport source (output valid, output pixel, output frame_start, input ready);
  modport sink   (input valid, input pixel, input frame_start, output ready);
endinterface

interface mp2d_result_if;
  import mp2d_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] pooled_value;
  logic [ROW_W-1:0]             out_row;
  logic [COL_W-1:0]             out_col;
  logic                         last_of_frame;

  modport source (output valid, output pooled_value, output out_row, output out_col,
                  output last_of_frame, input ready);
  modport sink   (input valid, input pooled_value, input out_row, input out_col,
                  input last_of_frame, output ready);
endinterface

`default_nettype wire

// ===== sv/mp2d_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mp2d_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== sv/mp2d_div.sv =====
// Restoring divider, one quotient bit per cycle, for the pooled row/column
// index and the stride grid test. Depends on mp2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mp2d_div (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire logic [mp2d_pkg::DIV_W-1:0] dividend,
  input  wire logic [mp2d_pkg::WS_W-1:0]  divisor,
  output logic      [mp2d_pkg::DIV_W-1:0] quotient,
  output logic      [mp2d_pkg::WS_W-1:0]  remainder,
  output logic                            done
);
  import mp2d_pkg::*;

  logic [DIV_CNT_W-1:0] cnt;
  logic [DIV_W-1:0]     quo;
  logic [WS_W-1:0]      rem;
  logic [WS_W:0]        trial;
  logic [WS_W:0]        diff;
  logic                 fits;

  // One trial subtraction per step
  assign trial = {rem, quo[DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = trial >= {1'b0, divisor};

  // Step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= DIV_CNT_W'(DIV_W);
    end else if (cnt != '0) begin
      cnt <= cnt - DIV_CNT_W'(1);
    end
  end

  // Partial remainder and quotient shift
  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
    end else if (cnt != '0) begin
      rem <= fits ? diff[WS_W-1:0] : trial[WS_W-1:0];
      quo <= {quo[DIV_W-2:0], fits};
    end
  end

  assign quotient  = quo;
  assign remainder = rem;
  assign done      = (cnt == '0);

endmodule

`default_nettype wire

// ===== sv/mp2d_ctrl.sv =====
// Controller state machine: sequences one pixel word through column max,
// index division and result load. Depends on mp2d_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mp2d_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire mp2d_pkg::dp_sts_t sts,
  output mp2d_pkg::dp_cmd_t      cmd
);
  import mp2d_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_COLMAX = 4'b0010,
    ST_DIVIDE = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        cmd.take = 1'b1;
        if (sts.in_valid) begin
          state_next = ST_COLMAX;
        end
      end
      ST_COLMAX: begin
        state_next = ST_IDLE;
        if (sts.row_ok) begin
          cmd.shift = 1'b1;
          if (sts.col_ok) begin
            cmd.div_start = 1'b1;
            state_next    = ST_DIVIDE;
          end
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_next = sts.rem_zero ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== sv/mp2d_dp.sv =====
// Datapath: configuration registers, frame position counters, row-banked
// line store, column max shift line, dividers and result register.
// Depends on mp2d_pkg, mp2d_channels, mp2d_ram and mp2d_div.
`timescale 1ns / 1ps
`default_nettype none

module mp2d_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                cfg_wr_en,
  input  wire mp2d_pkg::cfg_reg_t                  cfg_index,
  input  wire logic [mp2d_pkg::CFG_DATA_W-1:0]     cfg_data,
  mp2d_pixel_if.sink                               pixel_ch,
  mp2d_result_if.source                            result_ch,
  input  wire mp2d_pkg::dp_cmd_t                   cmd,
  output mp2d_pkg::dp_sts_t                        sts
);
  import mp2d_pkg::*;

  // Configuration registers and their effective values
  logic [FW_W-1:0] frame_width;
  logic [FH_W-1:0] frame_height;
  logic [KS_W-1:0] pool_side;
  logic [WS_W-1:0] window_stride;
  logic [FW_W-1:0] w_eff;
  logic [FH_W-1:0] h_eff;
  logic [KS_W-1:0] k_eff;
  logic [WS_W-1:0] s_eff;

  // Frame position
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_count;
  logic [ROW_W-1:0] r_sel;
  logic [COL_W-1:0] c_sel;
  logic [ROW_W:0]   r_inc;
  logic [COL_W:0]   c_inc;
  logic             accept;

  // Current word
  logic signed [DATA_WIDTH-1:0] px_q;
  logic [ROW_W-1:0]             r_q;
  logic [COL_W-1:0]             c_q;
  logic [ROW_W:0]               r_end;
  logic [COL_W:0]               c_end;
  logic [ROW_W:0]               row_diff;
  logic [COL_W:0]               col_diff;

  // Line store and maxima
  logic signed [DATA_WIDTH-1:0] bank_rd [MAX_KERNEL];
  logic signed [DATA_WIDTH-1:0] col_max;
  logic signed [DATA_WIDTH-1:0] col_shift [MAX_KERNEL];
  logic signed [DATA_WIDTH-1:0] win_max;

  // Dividers
  logic [DIV_W-1:0] row_quo;
  logic [DIV_W-1:0] col_quo;
  logic [WS_W-1:0]  row_rem;
  logic [WS_W-1:0]  col_rem;
  logic             row_done;
  logic             col_done;
  logic             last;

  // Result register
  logic                         res_valid;
  logic signed [DATA_WIDTH-1:0] res_value;
  logic [ROW_W-1:0]             res_row;
  logic [COL_W-1:0]             res_col;
  logic                         res_last;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= FW_RESET;
      frame_height  <= FH_RESET;
      pool_side     <= KS_RESET;
      window_stride <= WS_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:   frame_width   <= cfg_data[FW_W-1:0];
        CFG_FRAME_HEIGHT:  frame_height  <= cfg_data[FH_W-1:0];
        CFG_POOL_SIDE:     pool_side     <= cfg_data[KS_W-1:0];
        CFG_WINDOW_STRIDE: window_stride <= cfg_data[WS_W-1:0];
      endcase
    end
  end

  // Zero acts as one; oversized width, height and side values saturate
  always_comb begin
    w_eff = frame_width;
    if (frame_width == '0) w_eff = FW_W'(1);
    else if (frame_width > FW_W'(MAX_WIDTH)) w_eff = FW_W'(MAX_WIDTH);
    h_eff = frame_height;
    if (frame_height == '0) h_eff = FH_W'(1);
    else if (frame_height > FH_W'(MAX_HEIGHT)) h_eff = FH_W'(MAX_HEIGHT);
    k_eff = pool_side;
    if (pool_side == '0) k_eff = KS_W'(1);
    else if (pool_side > KS_W'(MAX_KERNEL)) k_eff = KS_W'(MAX_KERNEL);
    s_eff = (window_stride == '0) ? WS_W'(1) : window_stride;
  end

  // Accept handshake; frame start restarts the position
  assign pixel_ch.ready = cmd.take;
  assign accept = cmd.take & pixel_ch.valid;
  assign r_sel  = pixel_ch.frame_start ? '0 : row_count;
  assign c_sel  = pixel_ch.frame_start ? '0 : col_count;
  assign r_inc  = {1'b0, r_sel} + (ROW_W+1)'(1);
  assign c_inc  = {1'b0, c_sel} + (COL_W+1)'(1);

  // Position counters, wrap at row and frame end
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      if (c_inc >= (COL_W+1)'(w_eff)) begin
        col_count <= '0;
        row_count <= (r_inc >= (ROW_W+1)'(h_eff)) ? '0 : r_inc[ROW_W-1:0];
      end else begin
        col_count <= c_inc[COL_W-1:0];
        row_count <= r_sel;
      end
    end
  end

  // Latch the accepted word and its position
  always_ff @(posedge clk) begin
    if (accept) begin
      px_q <= pixel_ch.pixel;
      r_q  <= r_sel;
      c_q  <= c_sel;
    end
  end

  // Line store: one bank per row modulo the kernel depth, all read at once
  for (genvar b = 0; b < MAX_KERNEL; b++) begin : g_bank
    logic [DATA_WIDTH-1:0] rd_word;

    mp2d_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (MAX_WIDTH)
    ) u_bank (
      .clk     (clk),
      .wr_en   (accept && (r_sel[BANK_W-1:0] == BANK_W'(b))),
      .wr_addr (c_sel),
      .wr_data (pixel_ch.pixel),
      .rd_en   (accept),
      .rd_addr (c_sel),
      .rd_data (rd_word)
    );

    assign bank_rd[b] = rd_word;
  end

  // Column max over the current pixel and the k-1 rows above it
  always_comb begin
    logic [BANK_W-1:0] row_back;
    col_max = px_q;
    for (int b = 0; b < MAX_KERNEL; b++) begin
      row_back = r_q[BANK_W-1:0] - BANK_W'(b);
      if ((row_back != '0) && (KS_W'(row_back) < k_eff) && (bank_rd[b] > col_max)) begin
        col_max = bank_rd[b];
      end
    end
  end

  // Column max shift line
  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      col_shift[0] <= col_max;
      for (int j = 1; j < MAX_KERNEL; j++) begin
        col_shift[j] <= col_shift[j-1];
      end
    end
  end

  // Window test and pooled index dividends
  assign r_end    = {1'b0, r_q} + (ROW_W+1)'(1);
  assign c_end    = {1'b0, c_q} + (COL_W+1)'(1);
  assign row_diff = r_end - (ROW_W+1)'(k_eff);
  assign col_diff = c_end - (COL_W+1)'(k_eff);

  mp2d_div u_row_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (row_diff[DIV_W-1:0]),
    .divisor   (s_eff),
    .quotient  (row_quo),
    .remainder (row_rem),
    .done      (row_done)
  );

  mp2d_div u_col_div (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.div_start),
    .dividend  (DIV_W'(col_diff)),
    .divisor   (s_eff),
    .quotient  (col_quo),
    .remainder (col_rem),
    .done      (col_done)
  );

  // Window max over the newest k column maxima
  always_comb begin
    win_max = col_shift[0];
    for (int j = 1; j < MAX_KERNEL; j++) begin
      if ((KS_W'(j) < k_eff) && (col_shift[j] > win_max)) begin
        win_max = col_shift[j];
      end
    end
  end

  // No further window fits below or to the right
  assign last = ((r_end + (ROW_W+1)'(s_eff)) > (ROW_W+1)'(h_eff)) &&
                ((c_end + (COL_W+1)'(s_eff)) > (COL_W+1)'(w_eff));

  // Result register, holds while the receiver stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (result_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_value <= win_max;
      res_row   <= row_quo[ROW_W-1:0];
      res_col   <= col_quo[COL_W-1:0];
      res_last  <= last;
    end
  end

  assign result_ch.valid         = res_valid;
  assign result_ch.pooled_value  = res_value;
  assign result_ch.out_row       = res_row;
  assign result_ch.out_col       = res_col;
  assign result_ch.last_of_frame = res_last;

  // Status to the controller
  assign sts.in_valid = pixel_ch.valid;
  assign sts.row_ok   = r_end >= (ROW_W+1)'(k_eff);
  assign sts.col_ok   = c_end >= (COL_W+1)'(k_eff);
  assign sts.div_done = row_done & col_done;
  assign sts.rem_zero = (row_rem == '0) && (col_rem == '0);
  assign sts.out_free = !res_valid || result_ch.ready;

endmodule

`default_nettype wire

// ===== sv/max_pool_2d.sv =====
// Streaming 2D max pooling over a raster frame.
// Pixel words enter on pixel_ch (valid/ready) in row-major order; frame_start
// marks the first pixel of a frame. Pooled words leave on result_ch with the
// window maximum, its row and column in the pooled map, and last_of_frame on
// the final window of the frame. Registers (frame width, frame height, window
// side, window stride) are written through cfg_wr_en/cfg_index/cfg_data.
// A pixel that closes no candidate window passes only through the idle and
// column max states. A pixel whose column max closes a window candidate runs
// two 12-step restoring dividers for the pooled row/column and the stride
// grid test, then returns to idle when the window origin is off the grid or
// loads a result word once the output register is free. A new pixel is taken
// only in the idle state.
// The line store is one RAM bank per row modulo 8, 2048 words each; all banks
// are read at the pixel's column in the same cycle.
// Reset restores the register defaults (1200 x 1200, window 5, stride 5) and
// clears the frame position; the line store is not cleared.
// A stalled receiver holds the result word in the output register; the next
// pixel is still taken and worked on until its own result needs that register.
// Depends on mp2d_pkg, mp2d_channels, mp2d_ctrl and mp2d_dp.
`timescale 1ns / 1ps
`default_nettype none

module max_pool_2d (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire mp2d_pkg::cfg_reg_t              cfg_index,
  input  wire logic [mp2d_pkg::CFG_DATA_W-1:0] cfg_data,
  mp2d_pixel_if.sink                           pixel_ch,
  mp2d_result_if.source                        result_ch
);
  import mp2d_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  mp2d_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .cmd (cmd)
  );

  mp2d_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_ch  (pixel_ch),
    .result_ch (result_ch),
    .cmd       (cmd),
    .sts       (sts)
  );

`ifndef SYNTHESIS
  // One word at a time: no accept right after an accept
  a_single_word: assert property (@(posedge clk) disable iff (rst)
    (pixel_ch.valid && pixel_ch.ready) |=> !pixel_ch.ready)
    else $error("pixel word accepted while previous word in flight");

  // The result register is loaded only when it is free
  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> sts.out_free)
    else $error("result word overwritten before it was taken");

  // Column max pushed only once the frame holds a full window column
  a_shift_rows: assert property (@(posedge clk) disable iff (rst)
    cmd.shift |-> sts.row_ok)
    else $error("column max shifted without enough rows");

  // A new result word appears only after a load command
  a_valid_src: assert property (@(posedge clk) disable iff (rst)
    $rose(result_ch.valid) |-> $past(cmd.emit))
    else $error("result valid raised without a load");
`endif

endmodule

`default_nettype wire

// ===== verif/max_pool_2d_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for max_pool_2d: raster frames go in, pooled window maxima come out
// and are matched word by word against a behavioral pooling model kept in this file.
// Depends on mp2d_pkg, mp2d_channels and the max_pool_2d RTL.

module max_pool_2d_tb;
  import mp2d_pkg::*;

  localparam int CLK_HALF     = 5;
  localparam int RESET_CYCLES = 12;
  localparam int SETTLE       = 40;      // settle time after the queues drain
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 950;
  localparam int PHASE_CAP    = 160;
  localparam int CYCLE_LIMIT  = 500_000;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] px;
    logic                         sof;
  } raster_word_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] value;
    logic [ROW_W-1:0]             row;
    logic [COL_W-1:0]             col;
    logic                         last;
  } pooled_word_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_wr_en;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mp2d_pixel_if  pix_ch ();
  mp2d_result_if pool_ch ();

  max_pool_2d uut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pixel_ch  (pix_ch),
    .result_ch (pool_ch)
  );

  // Shadow of the block's registers
  logic [FW_W-1:0] fw_reg = FW_RESET;
  logic [FH_W-1:0] fh_reg = FH_RESET;
  logic [KS_W-1:0] ks_reg = KS_RESET;
  logic [WS_W-1:0] ws_reg = WS_RESET;

  // Pooling model state: recent rows, column maxima of the current row, frame position
  logic signed [DATA_WIDTH-1:0] row_bank [MAX_KERNEL][MAX_WIDTH];
  logic signed [DATA_WIDTH-1:0] colmax_line [MAX_KERNEL];
  int unsigned cur_row = 0;
  int unsigned cur_col = 0;

  raster_word_t raster_q [$];
  pooled_word_t pooled_due [$];
  raster_word_t next_word;
  pooled_word_t want_word;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_left      = 0;
  int holds_asked    = 0;
  int holds_served   = 0;
  int pixels_taken   = 0;
  int pooled_seen    = 0;
  int fails          = 0;
  int settings_done  = 0;
  int cycle_count    = 0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Pool one accepted pixel; queue the window max if it closes a window on the grid
  task automatic pool_pixel(input logic signed [DATA_WIDTH-1:0] px, input logic sof);
    int unsigned w, h, k, s, r, c;
    logic signed [DATA_WIDTH-1:0] col_max, win_max;
    pooled_word_t word;
    w = (fw_reg == 0) ? 1 : (fw_reg > MAX_WIDTH) ? MAX_WIDTH : fw_reg;
    h = (fh_reg == 0) ? 1 : (fh_reg > MAX_HEIGHT) ? MAX_HEIGHT : fh_reg;
    k = (ks_reg == 0) ? 1 : (ks_reg > MAX_KERNEL) ? MAX_KERNEL : ks_reg;
    s = (ws_reg == 0) ? 1 : ws_reg;
    if (sof) begin
      cur_row = 0;
      cur_col = 0;
    end
    r = cur_row % MAX_HEIGHT;
    c = cur_col % MAX_WIDTH;
    row_bank[r % MAX_KERNEL][c] = px;
    if (r + 1 >= k) begin
      col_max = px;
      for (int i = 1; i < k; i++)
        if (row_bank[(r - i) % MAX_KERNEL][c] > col_max)
          col_max = row_bank[(r - i) % MAX_KERNEL][c];
      for (int i = MAX_KERNEL - 1; i > 0; i--)
        colmax_line[i] = colmax_line[i-1];
      colmax_line[0] = col_max;
      if (c + 1 >= k && (r + 1 - k) % s == 0 && (c + 1 - k) % s == 0) begin
        win_max = colmax_line[0];
        for (int i = 1; i < k; i++)
          if (colmax_line[i] > win_max) win_max = colmax_line[i];
        word.value = win_max;
        word.row   = ROW_W'((r + 1 - k) / s);
        word.col   = COL_W'((c + 1 - k) / s);
        word.last  = (r + 1 + s > h) && (c + 1 + s > w);
        pooled_due.push_back(word);
      end
    end
    // counts wrap "at or beyond" the edge, so a shrunken frame wraps at once
    if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
  endtask

  // Pixel driver: predict on accept, then offer the next queued word or idle
  always @(posedge clk) begin
    if (rst) begin
      pix_ch.valid <= 1'b0;
    end else begin
      if (pix_ch.valid && pix_ch.ready) begin
        pool_pixel(pix_ch.pixel, pix_ch.frame_start);
        pixels_taken++;
      end
      if (!pix_ch.valid || pix_ch.ready) begin
        if (raster_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = raster_q.pop_front();
          pix_ch.valid       <= 1'b1;
          pix_ch.pixel       <= next_word.px;
          pix_ch.frame_start <= next_word.sof;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here on request from the sequence
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      hold_left    <= HOLD_CYCLES;
      holds_served <= holds_served + 1;
    end
  end

  // Result monitor: check each pooled word against the oldest expectation
  always @(posedge clk) begin
    if (rst) begin
      pool_ch.ready <= 1'b0;
    end else begin
      if (pool_ch.valid && pool_ch.ready) begin
        pooled_seen++;
        if (pooled_due.size() == 0) begin
          $error("unexpected pooled word: value %0d row %0d col %0d last %0d",
                 pool_ch.pooled_value, pool_ch.out_row, pool_ch.out_col,
                 pool_ch.last_of_frame);
          fails++;
        end else begin
          want_word = pooled_due.pop_front();
          if (pool_ch.pooled_value !== want_word.value) begin
            $error("pooled_value: expected %0d, got %0d",
                   $signed(want_word.value), pool_ch.pooled_value);
            fails++;
          end
          if (pool_ch.out_row !== want_word.row) begin
            $error("out_row: expected %0d, got %0d", want_word.row, pool_ch.out_row);
            fails++;
          end
          if (pool_ch.out_col !== want_word.col) begin
            $error("out_col: expected %0d, got %0d", want_word.col, pool_ch.out_col);
            fails++;
          end
          if (pool_ch.last_of_frame !== want_word.last) begin
            $error("last_of_frame: expected %0d, got %0d",
                   want_word.last, pool_ch.last_of_frame);
            fails++;
          end
        end
      end
      pool_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timed out after %0d cycles", CYCLE_LIMIT);
    $display("RESULT: ERROR");
    $finish;
  end

  // Write all four registers back to back; only called while the block is idle
  task automatic load_regs(input logic [CFG_DATA_W-1:0] w, h, k, s);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_FRAME_WIDTH;
    cfg_data  <= w;
    @(posedge clk);
    cfg_index <= CFG_FRAME_HEIGHT;
    cfg_data  <= h;
    @(posedge clk);
    cfg_index <= CFG_POOL_SIDE;
    cfg_data  <= k;
    @(posedge clk);
    cfg_index <= CFG_WINDOW_STRIDE;
    cfg_data  <= s;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fw_reg = w[FW_W-1:0];
    fh_reg = h[FH_W-1:0];
    ks_reg = k[KS_W-1:0];
    ws_reg = s[WS_W-1:0];
    settings_done++;
    @(negedge clk);
  endtask

  task automatic put(input logic signed [DATA_WIDTH-1:0] px, input logic sof);
    raster_q.push_back(raster_word_t'{px, sof});
  endtask

  // Wait until every word is sent and every pooled word is back, then let the block settle
  task automatic drain();
    do @(negedge clk);
    while (raster_q.size() != 0 || pix_ch.valid || pooled_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_idle(input int mode);
    case (mode % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
      default: begin send_idle_pct = 36; recv_stall_pct = 36; end
    endcase
  endtask

  // Samples: mostly uniform, with extremes and a cluster near zero for ties
  function automatic logic signed [DATA_WIDTH-1:0] rand_px();
    case ($urandom_range(9))
      0: rand_px = {1'b1, {(DATA_WIDTH-1){1'b0}}};
      1: rand_px = {1'b0, {(DATA_WIDTH-1){1'b1}}};
      2, 3: rand_px = DATA_WIDTH'($urandom_range(6)) - DATA_WIDTH'(3);
      default: rand_px = DATA_WIDTH'($urandom);
    endcase
  endfunction

  // One random setting and a run of small frames; some runs carry stray frame starts
  task automatic random_phase(input int idx, output int count);
    logic [CFG_DATA_W-1:0] wr, hr, kr, sr;
    int unsigned w_eff, h_eff, k_top, n;
    bit noisy;
    case ($urandom_range(11))
      0: wr = '0;
      1: wr = CFG_DATA_W'($urandom_range(12, 40));
      default: wr = CFG_DATA_W'($urandom_range(1, 10));
    endcase
    case ($urandom_range(11))
      0: hr = '0;
      1: hr = CFG_DATA_W'($urandom_range(9, 20));
      default: hr = CFG_DATA_W'($urandom_range(1, 8));
    endcase
    w_eff = (wr == 0) ? 1 : wr;
    h_eff = (hr == 0) ? 1 : hr;
    k_top = (w_eff < h_eff) ? w_eff : h_eff;
    if (k_top > 4) k_top = 4;
    case ($urandom_range(9))
      0: kr = '0;
      1: kr = CFG_DATA_W'($urandom_range(1, 15));
      default: kr = CFG_DATA_W'($urandom_range(1, k_top));
    endcase
    case ($urandom_range(9))
      0: sr = '0;
      1: sr = CFG_DATA_W'($urandom_range(4, 15));
      default: sr = CFG_DATA_W'($urandom_range(1, 3));
    endcase
    // bits above the field width must be dropped by the block
    if ($urandom_range(3) == 0) kr[CFG_DATA_W-1:KS_W] = (CFG_DATA_W-KS_W)'($urandom);
    if ($urandom_range(3) == 0) sr[CFG_DATA_W-1:WS_W] = (CFG_DATA_W-WS_W)'($urandom);
    load_regs(wr, hr, kr, sr);
    set_idle(idx);
    n = w_eff * h_eff;
    noisy = ($urandom_range(4) == 0);
    count = noisy ? $urandom_range(1, 3 * n) : $urandom_range(1, 3) * n;
    if (count > PHASE_CAP) count = PHASE_CAP;
    // first word always opens a frame, so a wider setting never reads stale rows
    for (int i = 0; i < count; i++)
      put(rand_px(), (i == 0) || (i % n == 0 && $urandom_range(1) == 1) ||
                     (noisy && $urandom_range(19) == 0));
    drain();
  endtask

  // Sequence: reset, directed frames, random settings, pressure run, wrap-up
  initial begin : sequence_main
    int random_items;
    int phase;
    int n;
    random_items = 0;
    phase = 0;
    cfg_wr_en = 1'b0;
    cfg_index = CFG_FRAME_WIDTH;
    cfg_data = '0;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = '0;
    pix_ch.frame_start = 1'b0;
    pool_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset settings, partial first row: sample extremes, nothing pooled
    put(-32768, 1'b0);
    put(32767, 1'b1);
    put(0, 1'b0);
    put(-1, 1'b0);
    drain();

    // all-zero registers act as one: every pixel is its own last window
    load_regs(0, 0, 0, 0);
    put(32767, 1'b1);
    put(-32768, 1'b0);
    put(5, 1'b0);
    drain();

    // 2x2 frame, one window of near-minimum values, then the frame wraps on its own
    load_regs(2, 2, 2, 1);
    put(-32768, 1'b1);
    put(-32767, 1'b0);
    put(-32768, 1'b0);
    put(-32768, 1'b0);
    put(32767, 1'b0);
    put(100, 1'b0);
    drain();

    // kernel larger than the frame: nothing pooled
    load_regs(3, 3, 5, 1);
    put(7, 1'b1);
    put(-7, 1'b0);
    put(1, 1'b0);
    put(2, 1'b0);
    drain();

    // width shrinks mid-frame: the column count is already past the edge and wraps
    load_regs(4, 3, 1, 1);
    put(10, 1'b1);
    put(11, 1'b0);
    put(12, 1'b0);
    put(13, 1'b0);
    put(14, 1'b0);
    drain();
    load_regs(1, 3, 1, 1);
    put(-20, 1'b0);
    put(21, 1'b0);
    drain();

    // oversized registers saturate
    load_regs(4095, 8191, 15, 15);
    put(3, 1'b1);
    put(-3, 1'b0);
    drain();

    // random settings, idling modes rotating; one run with a long receiver hold-off
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 2) begin
        load_regs(8, 8, 1, 1);
        set_idle(0);
        holds_asked++;
        for (int i = 0; i < 64; i++) put(rand_px(), i == 0);
        random_items += 64;
        drain();
      end else begin
        random_phase(phase, n);
        random_items += n;
      end
      phase++;
    end

    drain();
    $display("covered %0d pixel words over %0d register settings, %0d pooled words checked",
             pixels_taken, settings_done, pooled_seen);
    if (fails == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
